FILE: rtl/hkit_pkg.sv
// Package for the hashed key id table: request/result structs, codes,
// controller state type and the datapath command/status structs. No dependencies.
package hkit_pkg;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam logic [7:0]  PathSep  = 8'h2f;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_ERASE  = 2'd2,
    ACT_OTHER  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_NAME  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_COLLISION = 3'd4,
    ST_FULL      = 3'd5,
    ST_STORE_ERR = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] space_lo;
    logic [63:0] space_hi;
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [2:0]  value_type;
    logic [15:0] value_size;
    logic        data_write_ok;
    logic        table_write_ok;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [2:0]  stored_type;
    logic [15:0] stored_size;
    logic [6:0]  entry_count;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HASH,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic hash_init;  // start hashing
    logic hash_step;  // one byte
    logic scan_init;
    logic scan_rd;    // read entry at scan index
    logic scan_next;
    logic decide;     // compute outcome and apply
    logic move_rd;    // read last entry
    logic move_wr;    // write it into found slot
    logic finish;     // emit result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic names_ok;
    logic hash_done;
    logic scan_hit;   // found or collision at this entry
    logic scan_end;   // index reached count
    logic need_move;
  } sts_t;

  function automatic logic [7:0] byte_at(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [3:0] i);
    logic [127:0] w;
    w = {hi, lo};
    return w[{i, 3'b000} +: 8];
  endfunction

endpackage

FILE: rtl/hkit_ctrl.sv
// Controller state machine of the hashed key id table.
// Depends on hkit_pkg.
module hkit_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  hkit_pkg::sts_t  sts_i,
  output hkit_pkg::cmd_t  cmd_o,
  output logic            busy_o
);

  hkit_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= hkit_pkg::S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hkit_pkg::S_IDLE:     if (start_i) state_d = hkit_pkg::S_CHECK;
      hkit_pkg::S_CHECK:    state_d = sts_i.names_ok ? hkit_pkg::S_HASH : hkit_pkg::S_DONE;
      hkit_pkg::S_HASH:     if (sts_i.hash_done) state_d = hkit_pkg::S_SCAN_RD;
      hkit_pkg::S_SCAN_RD:  state_d = sts_i.scan_end ? hkit_pkg::S_DECIDE
                                                     : hkit_pkg::S_SCAN_CMP;
      hkit_pkg::S_SCAN_CMP: state_d = sts_i.scan_hit ? hkit_pkg::S_DECIDE
                                                     : hkit_pkg::S_SCAN_RD;
      hkit_pkg::S_DECIDE:   state_d = sts_i.need_move ? hkit_pkg::S_MOVE_RD
                                                      : hkit_pkg::S_DONE;
      hkit_pkg::S_MOVE_RD:  state_d = hkit_pkg::S_MOVE_WR;
      hkit_pkg::S_MOVE_WR:  state_d = hkit_pkg::S_DONE;
      hkit_pkg::S_DONE:     state_d = hkit_pkg::S_IDLE;
      default:              state_d = hkit_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != hkit_pkg::S_IDLE);
    unique case (state_q)
      hkit_pkg::S_IDLE:     cmd_o.load = start_i;
      hkit_pkg::S_CHECK:    begin
        cmd_o.hash_init = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      hkit_pkg::S_HASH:     cmd_o.hash_step = 1'b1;
      hkit_pkg::S_SCAN_RD:  cmd_o.scan_rd = 1'b1;
      hkit_pkg::S_SCAN_CMP: cmd_o.scan_next = 1'b1;
      hkit_pkg::S_DECIDE:   cmd_o.decide = 1'b1;
      hkit_pkg::S_MOVE_RD:  cmd_o.move_rd = 1'b1;
      hkit_pkg::S_MOVE_WR:  cmd_o.move_wr = 1'b1;
      hkit_pkg::S_DONE:     cmd_o.finish = 1'b1;
      default:              cmd_o = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("not busy after start");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !cmd_o.finish) else $error("finish repeated");
  a_move_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.move_rd |=> cmd_o.move_wr) else $error("move not completed");
`endif

endmodule

FILE: rtl/hkit_datapath.sv
// Datapath of the hashed key id table: name check, serial FNV-1a hash,
// entry memory with sequential scan, update and swap-erase. Depends on hkit_pkg.
module hkit_datapath #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned NameChars    = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hkit_pkg::cmd_t cmd_i,
  input  hkit_pkg::req_t req_i,
  output hkit_pkg::sts_t sts_o,
  output logic           done_o,
  output hkit_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW  = $clog2(TableEntries);
  localparam int unsigned CntW  = $clog2(TableEntries + 1);

  typedef struct packed {
    logic [31:0]  hash;
    logic [2:0]   vtype;
    logic [15:0]  vsize;
    logic [255:0] path;
  } ent_t;

  ent_t mem_q [TableEntries];

  hkit_pkg::req_t req_q;
  logic [127:0] sp_q, ky_q;
  logic [31:0]  hash_q;
  logic [4:0]   bpos_q;   // byte position, 0..15 space, then separator, then key
  logic         phase_q;  // 0 space, 1 key
  logic         hdone_q;
  logic [CntW-1:0] cnt_q, idx_q;
  ent_t         rd_q;
  logic         found_q, coll_q;
  logic [IdxW-1:0] fidx_q;
  logic [2:0]   st_q, rt_q;
  logic [15:0]  rs_q;
  logic         done_q;

  // name check and canonical form
  function automatic logic name_ok(input logic [127:0] w);
    logic ended;
    logic ok;
    ended = 1'b0;
    ok = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (i <= NameChars && !ended && w[i*8 +: 8] == 8'd0) begin
        ended = 1'b1;
        ok = (i != 0);
      end
    end
    return ok;
  endfunction

  function automatic logic [127:0] canon(input logic [127:0] w);
    logic [127:0] r;
    logic z;
    z = 1'b0;
    r = w;
    for (int i = 0; i < 16; i++) begin
      if (w[i*8 +: 8] == 8'd0) z = 1'b1;
      if (z) r[i*8 +: 8] = 8'd0;
    end
    return r;
  endfunction

  logic sp_ok, ky_ok;
  assign sp_ok = name_ok({req_q.space_hi, req_q.space_lo});
  assign ky_ok = name_ok({req_q.key_hi, req_q.key_lo});

  logic [7:0] cur_b;
  assign cur_b = phase_q ? ky_q[{bpos_q[3:0], 3'b000} +: 8]
                         : sp_q[{bpos_q[3:0], 3'b000} +: 8];

  logic [15:0] id_w, eid_w;
  assign id_w  = (hash_q[15:0] == 16'd0) ? 16'd1 : hash_q[15:0];
  assign eid_w = (rd_q.hash[15:0] == 16'd0) ? 16'd1 : rd_q.hash[15:0];

  logic match_w;
  assign match_w = (rd_q.hash == hash_q) && (rd_q.path == {sp_q, ky_q});

  logic [IdxW-1:0] last_w;
  assign last_w = IdxW'(cnt_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
    if (cmd_i.hash_init) begin
      sp_q    <= canon({req_q.space_hi, req_q.space_lo});
      ky_q    <= canon({req_q.key_hi, req_q.key_lo});
      hash_q  <= hkit_pkg::FnvBasis;
      bpos_q  <= '0;
      phase_q <= 1'b0;
      hdone_q <= 1'b0;
    end
    if (cmd_i.hash_step) begin
      if (cur_b == 8'd0 || bpos_q[4]) begin
        if (!phase_q) begin
          hash_q  <= (hash_q ^ {24'd0, hkit_pkg::PathSep}) * hkit_pkg::FnvPrime;
          phase_q <= 1'b1;
          bpos_q  <= '0;
        end else begin
          hdone_q <= 1'b1;
        end
      end else begin
        hash_q <= (hash_q ^ {24'd0, cur_b}) * hkit_pkg::FnvPrime;
        bpos_q <= bpos_q + 5'd1;
      end
    end
    if (cmd_i.scan_init) begin
      idx_q   <= '0;
      found_q <= 1'b0;
      coll_q  <= 1'b0;
    end
    if (cmd_i.scan_rd && idx_q != cnt_q) rd_q <= mem_q[idx_q[IdxW-1:0]];
    if (cmd_i.scan_next) begin
      if (match_w) begin
        found_q <= 1'b1;
        fidx_q  <= idx_q[IdxW-1:0];
      end else if (eid_w == id_w) begin
        coll_q <= 1'b1;
      end
      idx_q <= idx_q + CntW'(1);
    end
    if (cmd_i.move_rd) rd_q <= mem_q[last_w];
    if (cmd_i.move_wr) mem_q[fidx_q] <= rd_q;
    if (cmd_i.decide) begin
      if (req_q.action == hkit_pkg::ACT_WRITE && req_q.value_type >= 3'd1
          && req_q.value_type <= 3'd4) begin
        if (!found_q) begin
          if (cnt_q < CntW'(TableEntries) && !coll_q && req_q.data_write_ok
              && req_q.table_write_ok)
            mem_q[cnt_q[IdxW-1:0]] <= '{hash: hash_q, vtype: req_q.value_type,
                                        vsize: req_q.value_size, path: {sp_q, ky_q}};
        end else if (req_q.data_write_ok && req_q.table_write_ok) begin
          mem_q[fidx_q] <= '{hash: rd_q.hash, vtype: req_q.value_type,
                             vsize: req_q.value_size, path: rd_q.path};
        end
      end
    end
  end

  // outcome (combinational in decide)
  hkit_pkg::status_e dst;
  logic [2:0]  dtype;
  logic [15:0] dsize;
  logic        dadd, ddel, dmove;
  always_comb begin
    dst = hkit_pkg::ST_OK;
    dtype = '0;
    dsize = '0;
    dadd = 1'b0;
    ddel = 1'b0;
    dmove = 1'b0;
    unique case (req_q.action)
      hkit_pkg::ACT_WRITE: begin
        if (found_q) begin
          dtype = rd_q.vtype;
          dsize = rd_q.vsize;
        end
        if (req_q.value_type < 3'd1 || req_q.value_type > 3'd4) begin
          dst = hkit_pkg::ST_MISMATCH;
        end else if (!found_q) begin
          if (cnt_q >= CntW'(TableEntries)) dst = hkit_pkg::ST_FULL;
          else if (coll_q) dst = hkit_pkg::ST_COLLISION;
          else if (!req_q.data_write_ok || !req_q.table_write_ok)
            dst = hkit_pkg::ST_STORE_ERR;
          else begin
            dadd = 1'b1;
            dtype = req_q.value_type;
            dsize = req_q.value_size;
          end
        end else if (!req_q.data_write_ok) begin
          dst = hkit_pkg::ST_STORE_ERR;
        end else if (rd_q.vtype == req_q.value_type && rd_q.vsize == req_q.value_size) begin
          dst = hkit_pkg::ST_OK;
        end else if (!req_q.table_write_ok) begin
          dst = hkit_pkg::ST_STORE_ERR;
        end else begin
          dtype = req_q.value_type;
          dsize = req_q.value_size;
        end
      end
      hkit_pkg::ACT_ERASE: begin
        if (!found_q) begin
          dst = coll_q ? hkit_pkg::ST_COLLISION : hkit_pkg::ST_NOT_FOUND;
        end else begin
          dtype = rd_q.vtype;
          dsize = rd_q.vsize;
          if (!req_q.data_write_ok || !req_q.table_write_ok) begin
            dst = hkit_pkg::ST_STORE_ERR;
          end else begin
            ddel = 1'b1;
            dmove = (fidx_q != last_w);
          end
        end
      end
      default: begin
        if (!found_q) begin
          dst = coll_q ? hkit_pkg::ST_COLLISION : hkit_pkg::ST_NOT_FOUND;
        end else begin
          dtype = rd_q.vtype;
          dsize = rd_q.vsize;
          dst = (rd_q.vtype == req_q.value_type) ? hkit_pkg::ST_OK
                                                 : hkit_pkg::ST_MISMATCH;
        end
      end
    endcase
  end

  assign sts_o.names_ok  = sp_ok && ky_ok;
  assign sts_o.hash_done = hdone_q;
  assign sts_o.scan_end  = (idx_q == cnt_q);
  assign sts_o.scan_hit  = match_w || (eid_w == id_w);
  assign sts_o.need_move = dmove;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      st_q   <= '0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load) st_q <= hkit_pkg::ST_BAD_NAME;
      if (cmd_i.decide) begin
        st_q <= dst;
        if (dadd) cnt_q <= cnt_q + CntW'(1);
        if (ddel && !dmove) cnt_q <= cnt_q - CntW'(1);
      end
      if (cmd_i.move_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rt_q <= '0;
      rs_q <= '0;
    end
    if (cmd_i.decide) begin
      rt_q <= dtype;
      rs_q <= dsize;
    end
  end

  assign done_o = done_q;
  assign rsp_o.status      = st_q;
  assign rsp_o.entry_id    = (st_q == hkit_pkg::ST_BAD_NAME) ? 16'd0 : id_w;
  assign rsp_o.stored_type = rt_q;
  assign rsp_o.stored_size = rs_q;
  assign rsp_o.entry_count = 7'(cnt_q);

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TableEntries)) else $error("count overflow");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> idx_q <= cnt_q) else $error("scan past count");
  a_move_only_erase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.move_wr |-> req_q.action == hkit_pkg::ACT_ERASE) else $error("bad move");
`endif

endmodule

FILE: rtl/hashed_key_id_table.sv
// Top level of the hashed key id table: controller plus datapath.
// Depends on hkit_pkg, hkit_ctrl and hkit_datapath.
//
// Usage: drive req_i and pulse start while busy is low; the request is
// transferred at that edge. One result appears on rsp_o with valid_o high for
// exactly one cycle; the receiver cannot stall, so it must take it then.
// busy stays high from the transfer until the result cycle, in which it is
// already low, so the next request can be transferred at the result edge.
// A bad name goes from the check straight to the result. Otherwise the hash
// runs one byte per cycle over namespace, separator and key; the scan then
// reads and compares entries in turn until a hit or the count; the outcome
// is decided; and an erase that moves the last entry reads it and writes it
// into the found slot. Items run one at a time, so no new request is taken
// before the result; the serial hash and the one-read-port scan set the pace.
// Reset clears the controller and the entry count (table empty); the entry
// memory is not cleared, as only entries below the count are ever read.
module hashed_key_id_table #(
  parameter int unsigned TableEntries = 64,
  parameter int unsigned NameChars    = 15
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  hkit_pkg::req_t req_i,
  output logic           valid_o,
  output hkit_pkg::rsp_t rsp_o
);

  hkit_pkg::cmd_t cmd;
  hkit_pkg::sts_t sts;

  hkit_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  hkit_datapath #(
    .TableEntries(TableEntries),
    .NameChars   (NameChars)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .req_i (req_i),
    .sts_o (sts),
    .done_o(valid_o),
    .rsp_o (rsp_o)
  );

endmodule

FILE: bench/hkit_checker.sv
// Checker for the hashed key id table: watches request and result transfers,
// predicts each result from its own copy of the entry table and compares.
// Depends on hkit_pkg.
module hkit_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           busy,
  input  hkit_pkg::req_t req_i,
  input  logic           valid_o,
  input  hkit_pkg::rsp_t rsp_o,
  output int             errors_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hkit_pkg::*;

  localparam int Depth = 64;
  localparam int MaxChars = 15;

  logic [31:0]  tab_hash[Depth];
  logic [2:0]   tab_type[Depth];
  logic [15:0]  tab_size[Depth];
  logic [127:0] tab_space[Depth];
  logic [127:0] tab_key[Depth];
  int           tab_count;
  rsp_t         expected_q[$];

  function automatic bit canon_name(input logic [127:0] raw, output logic [127:0] canon);
    int len;
    len = 0;
    canon = '0;
    for (int i = 0; i < 16; i++) begin
      if (raw[8*i +: 8] == 8'h00) break;
      len++;
    end
    if (len == 0 || len > MaxChars) return 0;
    for (int i = 0; i < len; i++) canon[8*i +: 8] = raw[8*i +: 8];
    return 1;
  endfunction

  function automatic logic [31:0] fnv_name(input logic [31:0] h, input logic [127:0] name);
    for (int i = 0; i < 16; i++) begin
      if (name[8*i +: 8] == 8'h00) break;
      h = (h ^ {24'h0, name[8*i +: 8]}) * FnvPrime;
    end
    return h;
  endfunction

  function automatic logic [31:0] path_hash(input logic [127:0] space, input logic [127:0] key);
    logic [31:0] h;
    h = fnv_name(FnvBasis, space);
    h = (h ^ {24'h0, PathSep}) * FnvPrime;
    return fnv_name(h, key);
  endfunction

  function automatic logic [15:0] id_of(input logic [31:0] h);
    return (h[15:0] == 16'h0) ? 16'h1 : h[15:0];
  endfunction

  task automatic table_step(input req_t r, output rsp_t o);
    logic [127:0] sp, ky;
    logic [31:0]  h;
    logic [15:0]  id;
    int           found, n;
    bit           coll, names_ok;
    o = '0;
    found = -1;
    coll = 0;
    n = tab_count;
    names_ok = canon_name({r.space_hi, r.space_lo}, sp);
    if (names_ok) names_ok = canon_name({r.key_hi, r.key_lo}, ky);
    if (!names_ok) begin
      o.status = ST_BAD_NAME;
    end else begin
      h = path_hash(sp, ky);
      id = id_of(h);
      o.entry_id = id;
      for (int i = 0; i < n; i++) begin
        if (tab_hash[i] == h && tab_space[i] == sp && tab_key[i] == ky) begin
          found = i;
          break;
        end
        if (id_of(tab_hash[i]) == id) begin
          coll = 1;
          break;
        end
      end
      if (r.action == ACT_WRITE) begin
        if (r.value_type < 3'd1 || r.value_type > 3'd4) begin
          o.status = ST_MISMATCH;
        end else if (found < 0) begin
          if (n >= Depth) o.status = ST_FULL;
          else if (coll) o.status = ST_COLLISION;
          else if (!r.data_write_ok || !r.table_write_ok) o.status = ST_STORE_ERR;
          else begin
            tab_hash[n] = h;
            tab_type[n] = r.value_type;
            tab_size[n] = r.value_size;
            tab_space[n] = sp;
            tab_key[n] = ky;
            tab_count = n + 1;
            found = n;
          end
        end else begin
          if (!r.data_write_ok) o.status = ST_STORE_ERR;
          else if (tab_type[found] == r.value_type && tab_size[found] == r.value_size)
            o.status = ST_OK;
          else if (!r.table_write_ok) o.status = ST_STORE_ERR;
          else begin
            tab_type[found] = r.value_type;
            tab_size[found] = r.value_size;
          end
        end
        if (found >= 0) begin
          o.stored_type = tab_type[found];
          o.stored_size = tab_size[found];
        end
      end else if (r.action == ACT_ERASE) begin
        if (found < 0) begin
          o.status = coll ? ST_COLLISION : ST_NOT_FOUND;
        end else begin
          o.stored_type = tab_type[found];
          o.stored_size = tab_size[found];
          if (!r.data_write_ok || !r.table_write_ok) begin
            o.status = ST_STORE_ERR;
          end else begin
            tab_hash[found] = tab_hash[n-1];
            tab_type[found] = tab_type[n-1];
            tab_size[found] = tab_size[n-1];
            tab_space[found] = tab_space[n-1];
            tab_key[found] = tab_key[n-1];
            tab_count = n - 1;
          end
        end
      end else begin
        if (found < 0) begin
          o.status = coll ? ST_COLLISION : ST_NOT_FOUND;
        end else begin
          o.stored_type = tab_type[found];
          o.stored_size = tab_size[found];
          o.status = (tab_type[found] == r.value_type) ? ST_OK : ST_MISMATCH;
        end
      end
    end
    o.entry_count = 7'(tab_count);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want, got;
    if (!rst_ni) begin
      tab_count <= 0;
      expected_q.delete();
      pending_o <= 0;
      errors_o = 0;
    end else begin
      if (valid_o) begin
        got = rsp_o;
        if (expected_q.size() == 0) begin
          $display("%0t: result transfer with nothing expected", $realtime);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) report_mismatch("status", got.status, want.status);
          if (got.entry_id != want.entry_id)
            report_mismatch("entry_id", got.entry_id, want.entry_id);
          if (got.stored_type != want.stored_type)
            report_mismatch("stored_type", got.stored_type, want.stored_type);
          if (got.stored_size != want.stored_size)
            report_mismatch("stored_size", got.stored_size, want.stored_size);
          if (got.entry_count != want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
        end
      end
      if (start && !busy) begin
        table_step(req_i, want);
        expected_q.push_back(want);
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: bench/hashed_key_id_table_tb.sv
// Testbench top for the hashed key id table: clock, reset, request stimulus
// and verdict. Depends on hkit_pkg, hashed_key_id_table and hkit_checker.
module hashed_key_id_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hkit_pkg::*;

  localparam int NumSpaces = 3;
  localparam int NumKeys = 40;
  localparam int RandomItems = 1900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic valid_o;
  req_t req_i = '0;
  rsp_t rsp_o;
  int   errors;
  int   pending;
  bit   no_gaps = 0;

  logic [127:0] spaces[NumSpaces];
  logic [127:0] keys[NumKeys];
  logic [127:0] zero_key, coll_key;
  bit           have_zero, have_coll;

  hashed_key_id_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  hkit_checker u_chk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .valid_o  (valid_o),
    .rsp_o    (rsp_o),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand_name(input int len);
    logic [127:0] n;
    n = '0;
    for (int i = 0; i < len; i++) n[8*i +: 8] = 8'($urandom_range(255, 1));
    return n;
  endfunction

  // fill the bytes after the terminating NUL with noise
  function automatic logic [127:0] garble(input logic [127:0] canon);
    logic [127:0] mask;
    int len;
    len = 0;
    while (len < 16 && canon[8*len +: 8] != 8'h00) len++;
    mask = '0;
    for (int i = 0; i <= len && i < 16; i++) mask[8*i +: 8] = 8'hff;
    return canon | (rand128() & ~mask);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_gaps || r < 65) return 0;
    if (r < 95) return $urandom_range(5, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic req_t make_req(input action_e act, input logic [127:0] sp,
                                    input logic [127:0] ky, input logic [2:0] vt,
                                    input logic [15:0] vs, input bit dok, input bit tok);
    req_t r;
    {r.space_hi, r.space_lo} = garble(sp);
    {r.key_hi, r.key_lo} = garble(ky);
    r.action = act;
    r.value_type = vt;
    r.value_size = vs;
    r.data_write_ok = dok;
    r.table_write_ok = tok;
    return r;
  endfunction

  task automatic send(input req_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    start = 1'b0;
    repeat (gap) @(negedge clk_i);
    req_i = r;
    start = 1'b1;
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic req_t random_req(input bit filling);
    req_t r;
    int a, s, k;
    logic [127:0] sp, ky;
    action_e act;
    a = $urandom_range(99);
    if (filling) act = (a < 60) ? ACT_WRITE : (a < 85) ? ACT_LOOKUP : (a < 95) ? ACT_ERASE : ACT_OTHER;
    else act = (a < 25) ? ACT_WRITE : (a < 50) ? ACT_LOOKUP : (a < 95) ? ACT_ERASE : ACT_OTHER;
    s = $urandom_range(NumSpaces - 1);
    k = $urandom_range(NumKeys - 1);
    sp = spaces[s];
    ky = keys[k];
    a = $urandom_range(99);
    if (a < 2 && have_coll) begin
      sp = spaces[0];
      ky = $urandom_range(1) ? zero_key : coll_key;
    end else if (a < 3) begin
      sp = '0;
    end else if (a < 4) begin
      ky = rand_name(16);
    end else if (a < 5) begin
      ky = rand_name($urandom_range(15, 1));
    end
    r = make_req(act, sp, ky,
                 ($urandom_range(99) < 85) ? 3'($urandom_range(4, 1)) : 3'($urandom_range(7)),
                 ($urandom_range(99) < 70) ? 16'($urandom_range(3)) : 16'($urandom),
                 $urandom_range(99) < 90, $urandom_range(99) < 90);
    // a bad name must keep its noise where the name check stops
    if (sp == '0) {r.space_hi, r.space_lo} = {rand128()} & ~128'hff;
    if (ky[127:120] != 8'h00) {r.key_hi, r.key_lo} = ky;
    return r;
  endfunction

  initial begin
    logic [127:0] cand, sp0;
    logic [31:0]  h;
    int           tries;
    bit           filling;

    for (int i = 0; i < NumSpaces; i++) spaces[i] = rand_name($urandom_range(15, 1));
    for (int i = 0; i < NumKeys; i++) keys[i] = rand_name($urandom_range(15, 1));
    sp0 = spaces[0];
    have_zero = 0;
    have_coll = 0;
    tries = 0;
    while (!(have_zero && have_coll) && tries < 800000) begin
      cand = rand_name($urandom_range(6, 1));
      h = u_chk.path_hash(sp0, cand);
      if (!have_zero && h[15:0] == 16'h0) begin
        zero_key = cand;
        have_zero = 1;
      end else if (!have_coll && h[15:0] == 16'h1) begin
        coll_key = cand;
        have_coll = 1;
      end
      tries++;
    end
    have_coll = have_zero && have_coll;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    if (have_coll) begin
      send(make_req(ACT_WRITE, sp0, zero_key, 3'd1, 16'd5, 1, 1));
      send(make_req(ACT_WRITE, sp0, coll_key, 3'd2, 16'd5, 1, 1));
      send(make_req(ACT_LOOKUP, sp0, coll_key, 3'd2, 16'd0, 1, 1));
      send(make_req(ACT_ERASE, sp0, coll_key, 3'd2, 16'd0, 1, 1));
      send(make_req(ACT_LOOKUP, sp0, zero_key, 3'd1, 16'd0, 1, 1));
    end
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd3, 16'hffff, 1, 0));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd3, 16'hffff, 1, 1));
    send(make_req(ACT_LOOKUP, sp0, keys[0], 3'd4, 16'd0, 1, 1));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd3, 16'hffff, 1, 0));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd4, 16'd0, 1, 0));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd4, 16'd0, 0, 1));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd4, 16'd0, 1, 1));
    send(make_req(ACT_WRITE, sp0, keys[0], 3'd0, 16'd1, 1, 1));
    send(make_req(ACT_WRITE, sp0, keys[1], 3'd7, 16'd1, 1, 1));
    send(make_req(ACT_OTHER, sp0, keys[0], 3'd4, 16'd0, 1, 1));
    send(make_req(ACT_WRITE, '0, keys[0], 3'd1, 16'd1, 1, 1));
    send(make_req(ACT_WRITE, sp0, '0, 3'd1, 16'd1, 1, 1));
    send(make_req(ACT_WRITE, sp0, rand_name(16), 3'd1, 16'd1, 1, 1));
    send(make_req(ACT_WRITE, {8'h00, {15{8'hff}}}, {8'h00, {15{8'hff}}}, 3'd2, 16'd9, 1, 1));
    send(make_req(ACT_LOOKUP, {8'h00, {15{8'hff}}}, {8'h00, {15{8'hff}}}, 3'd2, 16'd0, 1, 1));
    send(make_req(ACT_ERASE, sp0, keys[0], 3'd1, 16'd0, 0, 1));
    send(make_req(ACT_ERASE, sp0, keys[0], 3'd1, 16'd0, 1, 1));
    send(make_req(ACT_ERASE, sp0, keys[0], 3'd1, 16'd0, 1, 1));
    send(make_req(ACT_LOOKUP, sp0, keys[2], 3'd1, 16'd0, 1, 1));
    drain();

    for (int n = 0; n < RandomItems; n++) begin
      if (n % 200 == 0) begin
        filling = ((n / 200) % 2) == 0;
        no_gaps = ((n / 200) % 3) == 2;
        if ((n / 200) % 2 == 1) drain();
      end
      send(random_req(filling));
    end

    drain();
    repeat (150) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
